// ===== sv/csra_pkg.sv =====
// Shared types, field widths and codes for the adjacency store.
package csra_pkg;

   // Payload field widths.
   localparam int FUNC_W   = 3;
   localparam int NODE_W   = 31;
   localparam int POS_W    = 12;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 32;

   // Width of the shared adder; wide enough for any node difference or pointer sum.
   localparam int ALU_W = 34;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FN_ADD      = 3'd0;
   localparam logic [FUNC_W-1:0] FN_FINISH   = 3'd1;
   localparam logic [FUNC_W-1:0] FN_DEGREE   = 3'd2;
   localparam logic [FUNC_W-1:0] FN_CONTAINS = 3'd3;
   localparam logic [FUNC_W-1:0] FN_EDGE_AT  = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Value reported for an invalid node or index, and the reset of min_node.
   localparam logic [VALUE_W-1:0] VAL_INVALID    = 32'hFFFF_FFFF;
   localparam logic [CSR_W-1:0]   MIN_NODE_RESET = 32'hFFFF_FFFF;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // Request to the shared adder.
   typedef struct packed {
      alu_op_type       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   // Answer of the shared adder.
   typedef struct packed {
      logic [ALU_W-1:0] res;
      logic             neg;
   } alu_rsp_type;

endpackage

// ===== sv/csra_ifs.sv =====
// Channel interfaces of the adjacency store: request, response and register write.

// Request channel: one operation per transfer.
interface csra_req_if;
   logic                          valid;
   logic                          ready;
   logic [csra_pkg::FUNC_W-1:0]   func;
   logic [csra_pkg::NODE_W-1:0]   node_id;
   logic [csra_pkg::NODE_W-1:0]   target_id;
   logic [csra_pkg::POS_W-1:0]    position;

   modport source (output valid, func, node_id, target_id, position, input ready);
   modport sink   (input valid, func, node_id, target_id, position, output ready);
endinterface

// Response channel: one result per request.
interface csra_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [csra_pkg::VALUE_W-1:0]  value;
   logic                          found;
   logic [csra_pkg::STATUS_W-1:0] status;

   modport source (output valid, value, found, status, input ready);
   modport sink   (input valid, value, found, status, output ready);
endinterface

// Register write channel for min_node.
interface csra_csr_if;
   logic                          valid;
   logic                          ready;
   logic [csra_pkg::CSR_W-1:0]    data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== sv/csra_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module csra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/csra_alu.sv =====
// Shared adder/subtractor used by the sequencer for every count and address and for the address-bound compares.
module csra_alu (
   input  csra_pkg::alu_req_type req,
   output csra_pkg::alu_rsp_type rsp
);

   logic [csra_pkg::ALU_W-1:0] b_eff;
   logic                       carry;

   // Subtraction adds the inverted operand plus one.
   always_comb begin
      case (req.op)
         csra_pkg::ALU_SUB: begin
            b_eff = ~req.b;
            carry = 1'b1;
         end
         default: begin
            b_eff = req.b;
            carry = 1'b0;
         end
      endcase
      rsp.res = req.a + b_eff + csra_pkg::ALU_W'(carry);
      rsp.neg = rsp.res[csra_pkg::ALU_W-1];
   end

endmodule

// ===== sv/csra_ctrl.sv =====
// Sequencer of the adjacency store: decodes requests and steps the shared adder.
module csra_ctrl #(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096,
   localparam int RW  = $clog2(MAX_NODES + 2),
   localparam int PIW = $clog2(MAX_NODES + 1),
   localparam int EW  = $clog2(MAX_EDGES + 1),
   localparam int EIW = $clog2(MAX_EDGES)
) (
   input  logic                          clock,
   input  logic                          reset,
   csra_req_if.sink                      req_bus,
   csra_rsp_if.source                    rsp_bus,
   input  logic [csra_pkg::CSR_W-1:0]    min_node,
   output csra_pkg::alu_req_type         alu_req,
   input  csra_pkg::alu_rsp_type         alu_rsp,
   output logic                          ptr_wr_en,
   output logic [PIW-1:0]                ptr_wr_addr,
   output logic [EW-1:0]                 ptr_wr_data,
   output logic                          ptr_rd_en,
   output logic [PIW-1:0]                ptr_rd_addr,
   input  logic [EW-1:0]                 ptr_rd_data,
   output logic                          edge_wr_en,
   output logic [EIW-1:0]                edge_wr_addr,
   output logic [csra_pkg::NODE_W-1:0]   edge_wr_data,
   output logic                          edge_rd_en,
   output logic [EIW-1:0]                edge_rd_addr,
   input  logic [csra_pkg::NODE_W-1:0]   edge_rd_data
);

   // Address register wide enough for a row start plus the largest offset.
   localparam int AW = ((EW > csra_pkg::POS_W) ? EW : csra_pkg::POS_W) + 1;

   typedef enum logic [15:0] {
      S_IDLE     = 16'b0000_0000_0000_0001,
      S_ROWIDX   = 16'b0000_0000_0000_0010,
      S_DISPATCH = 16'b0000_0000_0000_0100,
      S_FILL     = 16'b0000_0000_0000_1000,
      S_APPEND   = 16'b0000_0000_0001_0000,
      S_CLOSE    = 16'b0000_0000_0010_0000,
      S_RDA      = 16'b0000_0000_0100_0000,
      S_RDB      = 16'b0000_0000_1000_0000,
      S_RDC      = 16'b0000_0001_0000_0000,
      S_DIFF     = 16'b0000_0010_0000_0000,
      S_ADDR     = 16'b0000_0100_0000_0000,
      S_ECHK     = 16'b0000_1000_0000_0000,
      S_EDATA    = 16'b0001_0000_0000_0000,
      S_SCAN_CHK = 16'b0010_0000_0000_0000,
      S_SCAN_CMP = 16'b0100_0000_0000_0000,
      S_RESP     = 16'b1000_0000_0000_0000
   } state_type;

   state_type                      state_ff, state_in;
   logic [csra_pkg::FUNC_W-1:0]    func_ff, func_in;
   logic [csra_pkg::NODE_W-1:0]    node_ff, node_in;
   logic [csra_pkg::NODE_W-1:0]    target_ff, target_in;
   logic [csra_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [csra_pkg::ALU_W-1:0]     r_ff, r_in;
   logic [RW-1:0]                  row_count_ff, row_count_in;
   logic [EW-1:0]                  edge_count_ff, edge_count_in;
   logic [EW-1:0]                  start_ff, start_in;
   logic [EW-1:0]                  end_ff, end_in;
   logic [AW-1:0]                  a_ff, a_in;
   logic [csra_pkg::VALUE_W-1:0]   val_ff, val_in;
   logic                           fnd_ff, fnd_in;
   logic [csra_pkg::STATUS_W-1:0]  st_ff, st_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [csra_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                           rsp_found_ff, rsp_found_in;
   logic [csra_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic          r_neg;
   logic          r_small;
   logic [RW-1:0] r_lo;
   logic          r_lt_rc;
   logic          r_closed;
   logic          r_in_cap;
   logic          edges_full;
   logic          rows_full;

   // Row index checks against the pointer count and the node capacity, and the store-full flags.
   assign r_neg      = r_ff[csra_pkg::ALU_W-1];
   assign r_small    = (r_ff[csra_pkg::ALU_W-1:RW] == '0);
   assign r_lo       = r_ff[RW-1:0];
   assign r_lt_rc    = r_small && (r_lo < row_count_ff);
   assign r_closed   = r_small && (({1'b0, r_lo} + (RW+1)'(1)) < {1'b0, row_count_ff});
   assign r_in_cap   = r_small && (r_lo < RW'(MAX_NODES));
   assign edges_full = (edge_count_ff >= EW'(MAX_EDGES));
   assign rows_full  = (row_count_ff >= RW'(MAX_NODES + 1));

   // Handshake outputs.
   assign req_bus.ready  = (state_ff == S_IDLE);
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.value  = rsp_value_ff;
   assign rsp_bus.found  = rsp_found_ff;
   assign rsp_bus.status = rsp_status_ff;

   // Sequencer: next state, adder operands and memory strobes.
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      node_in       = node_ff;
      target_in     = target_ff;
      pos_in        = pos_ff;
      r_in          = r_ff;
      row_count_in  = row_count_ff;
      edge_count_in = edge_count_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      a_in          = a_ff;
      val_in        = val_ff;
      fnd_in        = fnd_ff;
      st_in         = st_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;

      alu_req.op = csra_pkg::ALU_ADD;
      alu_req.a  = '0;
      alu_req.b  = '0;

      ptr_wr_en    = 1'b0;
      ptr_wr_addr  = row_count_ff[PIW-1:0];
      ptr_wr_data  = edge_count_ff;
      ptr_rd_en    = 1'b0;
      ptr_rd_addr  = r_lo[PIW-1:0];
      edge_wr_en   = 1'b0;
      edge_wr_addr = edge_count_ff[EIW-1:0];
      edge_wr_data = target_ff;
      edge_rd_en   = 1'b0;
      edge_rd_addr = a_ff[EIW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               func_in   = req_bus.func;
               node_in   = req_bus.node_id;
               target_in = req_bus.target_id;
               pos_in    = req_bus.position;
               state_in  = S_ROWIDX;
            end
         end
         S_ROWIDX: begin
            // Row index is node_id minus min_node, as a signed value.
            alu_req.op = csra_pkg::ALU_SUB;
            alu_req.a  = csra_pkg::ALU_W'(node_ff);
            alu_req.b  = csra_pkg::ALU_W'(signed'(min_node));
            r_in       = alu_rsp.res;
            val_in     = '0;
            fnd_in     = 1'b0;
            st_in      = csra_pkg::ST_OK;
            state_in   = S_DISPATCH;
         end
         S_DISPATCH: begin
            unique case (func_ff) inside
               csra_pkg::FN_ADD: begin
                  if (edges_full) begin
                     st_in    = csra_pkg::ST_FULL;
                     state_in = S_RESP;
                  end else if (!r_neg && !r_lt_rc) begin
                     if (!r_in_cap) begin
                        st_in    = csra_pkg::ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_FILL;
                     end
                  end else begin
                     state_in = S_APPEND;
                  end
               end
               csra_pkg::FN_FINISH: begin
                  if (rows_full) begin
                     st_in    = csra_pkg::ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_CLOSE;
                  end
               end
               csra_pkg::FN_DEGREE, csra_pkg::FN_CONTAINS: begin
                  if (!r_closed) begin
                     val_in   = csra_pkg::VAL_INVALID;
                     st_in    = csra_pkg::ST_RANGE;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_RDA;
                  end
               end
               csra_pkg::FN_EDGE_AT: begin
                  if (r_neg || !r_lt_rc) begin
                     val_in   = csra_pkg::VAL_INVALID;
                     st_in    = csra_pkg::ST_RANGE;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_RDA;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_FILL: begin
            // One row-start pointer per cycle until the source row exists.
            ptr_wr_en    = 1'b1;
            alu_req.a    = csra_pkg::ALU_W'(row_count_ff);
            alu_req.b    = csra_pkg::ALU_W'(1);
            row_count_in = alu_rsp.res[RW-1:0];
            if (row_count_ff == r_lo) begin
               state_in = S_APPEND;
            end
         end
         S_APPEND: begin
            edge_wr_en    = 1'b1;
            alu_req.a     = csra_pkg::ALU_W'(edge_count_ff);
            alu_req.b     = csra_pkg::ALU_W'(1);
            edge_count_in = alu_rsp.res[EW-1:0];
            state_in      = S_RESP;
         end
         S_CLOSE: begin
            ptr_wr_en    = 1'b1;
            alu_req.a    = csra_pkg::ALU_W'(row_count_ff);
            alu_req.b    = csra_pkg::ALU_W'(1);
            row_count_in = alu_rsp.res[RW-1:0];
            state_in     = S_RESP;
         end
         S_RDA: begin
            ptr_rd_en = 1'b1;
            state_in  = S_RDB;
         end
         S_RDB: begin
            // Row start arrives; fetch the next pointer unless only the start is needed.
            start_in = ptr_rd_data;
            if (func_ff == csra_pkg::FN_EDGE_AT) begin
               state_in = S_ADDR;
            end else begin
               alu_req.a   = r_ff;
               alu_req.b   = csra_pkg::ALU_W'(1);
               ptr_rd_en   = 1'b1;
               ptr_rd_addr = alu_rsp.res[PIW-1:0];
               state_in    = S_RDC;
            end
         end
         S_RDC: begin
            end_in = ptr_rd_data;
            a_in   = AW'(start_ff);
            if (func_ff == csra_pkg::FN_DEGREE) begin
               state_in = S_DIFF;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_DIFF: begin
            alu_req.op = csra_pkg::ALU_SUB;
            alu_req.a  = csra_pkg::ALU_W'(end_ff);
            alu_req.b  = csra_pkg::ALU_W'(start_ff);
            val_in     = alu_rsp.res[csra_pkg::VALUE_W-1:0];
            state_in   = S_RESP;
         end
         S_ADDR: begin
            alu_req.a = csra_pkg::ALU_W'(start_ff);
            alu_req.b = csra_pkg::ALU_W'(pos_ff);
            a_in      = alu_rsp.res[AW-1:0];
            state_in  = S_ECHK;
         end
         S_ECHK: begin
            // The address must lie below the edge count.
            alu_req.op = csra_pkg::ALU_SUB;
            alu_req.a  = csra_pkg::ALU_W'(a_ff);
            alu_req.b  = csra_pkg::ALU_W'(edge_count_ff);
            if (!alu_rsp.neg) begin
               val_in   = csra_pkg::VAL_INVALID;
               st_in    = csra_pkg::ST_RANGE;
               state_in = S_RESP;
            end else begin
               edge_rd_en = 1'b1;
               state_in   = S_EDATA;
            end
         end
         S_EDATA: begin
            val_in   = csra_pkg::VALUE_W'(edge_rd_data);
            state_in = S_RESP;
         end
         S_SCAN_CHK: begin
            // Stop at the row end, otherwise read the next neighbor.
            alu_req.op = csra_pkg::ALU_SUB;
            alu_req.a  = csra_pkg::ALU_W'(a_ff);
            alu_req.b  = csra_pkg::ALU_W'(end_ff);
            if (!alu_rsp.neg) begin
               state_in = S_RESP;
            end else begin
               edge_rd_en = 1'b1;
               state_in   = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (edge_rd_data == target_ff) begin
               fnd_in   = 1'b1;
               state_in = S_RESP;
            end else begin
               alu_req.a = csra_pkg::ALU_W'(a_ff);
               alu_req.b = csra_pkg::ALU_W'(1);
               a_in      = alu_rsp.res[AW-1:0];
               state_in  = S_SCAN_CHK;
            end
         end
         S_RESP: begin
            // Move the result into the output register once it is free.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = val_ff;
               rsp_found_in  = fnd_ff;
               rsp_status_in = st_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         row_count_ff  <= '0;
         edge_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_count_ff  <= row_count_in;
         edge_count_ff <= edge_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      node_ff       <= node_in;
      target_ff     <= target_in;
      pos_ff        <= pos_in;
      r_ff          <= r_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      a_ff          <= a_in;
      val_ff        <= val_in;
      fnd_ff        <= fnd_in;
      st_ff         <= st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ===== sv/csr_adjacency_store.sv =====
// Compressed-sparse-row adjacency store: builds rows from grouped edges and answers queries.
//
// Channels: req_bus carries one operation per transfer (add edge, finish, degree,
// contains, edge at position); rsp_bus returns exactly one result per request;
// csr_bus writes min_node, the node identifier of row zero, and is always ready.
// Write min_node only while no request is in flight.
// One request at a time; counts, addresses and address checks share one adder.
// Each request first forms its row index and is decoded; add edge then fills any
// missing row pointers and appends the edge, finish closes the row, degree reads
// two row pointers, edge at position adds the position to the row start and reads
// the edge if the address lies below the edge count, and contains walks the row's
// neighbors; requests rejected at decode (range or full) go straight to the result.
// The request channel reopens as the result appears in the output register.
// The pointer and edge memories each have one write and one registered read port,
// so each neighbor in the contains walk takes a check state and a compare state.
// Reset clears the pointer and edge counts, sets min_node to -1 and empties the
// output register; the memories are not cleared. A result waits in the output
// register while the receiver stalls; the next request is still taken meanwhile,
// and its result waits until the register is free.
module csr_adjacency_store #(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   csra_req_if.sink   req_bus,
   csra_rsp_if.source rsp_bus,
   csra_csr_if.sink   csr_bus
);

   localparam int PIW = $clog2(MAX_NODES + 1);
   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int EIW = $clog2(MAX_EDGES);

   logic [csra_pkg::CSR_W-1:0] min_node_ff;

   csra_pkg::alu_req_type alu_req;
   csra_pkg::alu_rsp_type alu_rsp;

   logic                        ptr_wr_en;
   logic [PIW-1:0]              ptr_wr_addr;
   logic [EW-1:0]               ptr_wr_data;
   logic                        ptr_rd_en;
   logic [PIW-1:0]              ptr_rd_addr;
   logic [EW-1:0]               ptr_rd_data;
   logic                        edge_wr_en;
   logic [EIW-1:0]              edge_wr_addr;
   logic [csra_pkg::NODE_W-1:0] edge_wr_data;
   logic                        edge_rd_en;
   logic [EIW-1:0]              edge_rd_addr;
   logic [csra_pkg::NODE_W-1:0] edge_rd_data;

   // The min_node register takes every write transfer.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_node_ff <= csra_pkg::MIN_NODE_RESET;
      end else if (csr_bus.valid) begin
         min_node_ff <= csr_bus.data;
      end
   end

   // Sequencer.
   csra_ctrl #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .min_node     (min_node_ff),
      .alu_req      (alu_req),
      .alu_rsp      (alu_rsp),
      .ptr_wr_en    (ptr_wr_en),
      .ptr_wr_addr  (ptr_wr_addr),
      .ptr_wr_data  (ptr_wr_data),
      .ptr_rd_en    (ptr_rd_en),
      .ptr_rd_addr  (ptr_rd_addr),
      .ptr_rd_data  (ptr_rd_data),
      .edge_wr_en   (edge_wr_en),
      .edge_wr_addr (edge_wr_addr),
      .edge_wr_data (edge_wr_data),
      .edge_rd_en   (edge_rd_en),
      .edge_rd_addr (edge_rd_addr),
      .edge_rd_data (edge_rd_data)
   );

   // Shared adder.
   csra_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // Row-start pointer memory, one slot more than the node capacity.
   csra_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_NODES + 1)
   ) u_ptr_ram (
      .clock   (clock),
      .wr_en   (ptr_wr_en),
      .wr_addr (ptr_wr_addr),
      .wr_data (ptr_wr_data),
      .rd_en   (ptr_rd_en),
      .rd_addr (ptr_rd_addr),
      .rd_data (ptr_rd_data)
   );

   // Edge target memory.
   csra_ram #(
      .WIDTH (csra_pkg::NODE_W),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (edge_wr_addr),
      .wr_data (edge_wr_data),
      .rd_en   (edge_rd_en),
      .rd_addr (edge_rd_addr),
      .rd_data (edge_rd_data)
   );

endmodule

// ===== sv/csra_checker.sv =====
// Port-level assertions for the adjacency store, bound to the top level.
module csra_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [csra_pkg::VALUE_W-1:0]  rsp_value,
   input logic                          rsp_found,
   input logic [csra_pkg::STATUS_W-1:0] rsp_status
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // One request at a time: a request transfer closes the request channel.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // A hit is only reported with status ok and value zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == csra_pkg::ST_OK && rsp_value == '0)
      else $error("found flag with bad status or value");

   // A range error always carries the invalid value and no hit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == csra_pkg::ST_RANGE
         |-> rsp_value == csra_pkg::VAL_INVALID && !rsp_found)
      else $error("range error without invalid value");

   // A full store reports value zero and no hit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == csra_pkg::ST_FULL |-> rsp_value == '0 && !rsp_found)
      else $error("store full with nonzero value");

endmodule

bind csr_adjacency_store csra_checker u_csra_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_value  (rsp_bus.value),
   .rsp_found  (rsp_bus.found),
   .rsp_status (rsp_bus.status)
);
